// ----- rtl/core/kabf_pkg.sv -----
package kabf_pkg;

    localparam int FRAC_BITS = 24;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 33;
    localparam int MUL_RES_W = MUL_A_W + MUL_B_W - FRAC_BITS;
    localparam int WIDE_W    = 48;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_DVD_W = 32 + FRAC_BITS;

    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd3;

    localparam logic [30:0] ANGLE_NOISE_RST   = 31'd16777;
    localparam logic [30:0] BIAS_NOISE_RST    = 31'd50332;
    localparam logic [30:0] MEASURE_NOISE_RST = 31'd503316;
    localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd167772;

    typedef enum logic [3:0] {
        OP_ANGLE_PRED = 4'd0,
        OP_DT_P11     = 4'd1,
        OP_P00_PRED   = 4'd2,
        OP_P11_PRED   = 4'd3,
        OP_GAIN0      = 4'd4,
        OP_GAIN1      = 4'd5,
        OP_ANGLE_UPD  = 4'd6,
        OP_BIAS_UPD   = 4'd7,
        OP_P00_UPD    = 4'd8,
        OP_P01_UPD    = 4'd9,
        OP_P10_UPD    = 4'd10,
        OP_P11_UPD    = 4'd11
    } step_t;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = -WIDE_W'(64'sd2147483648);
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [WIDE_W-1:0] sx32(input logic [31:0] v);
        sx32 = {{(WIDE_W-32){v[31]}}, v};
    endfunction

endpackage

// ----- rtl/core/kabf_mul.sv -----
module kabf_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [kabf_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [kabf_pkg::MUL_B_W-1:0]  op_b,
    output logic                                 done,
    output logic signed [kabf_pkg::MUL_RES_W-1:0] result
);
    import kabf_pkg::*;

    localparam int PROD_W = MUL_A_W + MUL_B_W;

    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    rounded;
    logic                        stage1_reg;
    logic                        done_reg;
    logic signed [MUL_RES_W-1:0] result_reg;

    // round half up, then floor
    assign rounded = prod_reg + (PROD_W'(1) <<< (FRAC_BITS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            stage1_reg <= start;
            done_reg   <= stage1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= op_a * op_b;
        end
        if (stage1_reg) begin
            result_reg <= rounded[PROD_W-1:FRAC_BITS];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/kabf_div.sv -----
module kabf_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [31:0]                    numer,
    input  logic signed [kabf_pkg::DIV_DEN_W-1:0] denom,
    output logic                                  done,
    output logic signed [31:0]                    quot
);
    import kabf_pkg::*;

    localparam int CNT_W = $clog2(DIV_DVD_W + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIV_DVD_W-1:0]   dvd_reg;
    logic [DIV_DEN_W-1:0]   dsr_reg;
    logic [DIV_DEN_W:0]     rem_reg;
    logic                   neg_reg;
    logic                   zero_reg;
    logic signed [31:0]     quot_reg;

    logic [31:0]            num_mag;
    logic [DIV_DEN_W-1:0]   den_mag;
    logic [DIV_DEN_W:0]     rem_sh;
    logic [DIV_DEN_W:0]     rem_sub;
    logic                   q_bit;
    logic [DIV_DVD_W-1:0]   q_final;

    assign num_mag = numer[31] ? 32'(-numer) : 32'(numer);
    assign den_mag = denom[DIV_DEN_W-1] ? DIV_DEN_W'(-denom) : DIV_DEN_W'(denom);

    assign rem_sh  = {rem_reg[DIV_DEN_W-1:0], dvd_reg[DIV_DVD_W-1]};
    assign q_bit   = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = q_bit ? rem_sh - {1'b0, dsr_reg} : rem_sh;
    assign q_final = {dvd_reg[DIV_DVD_W-2:0], q_bit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out from the top while quotient bits shift in below
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
            dsr_reg  <= den_mag;
            rem_reg  <= '0;
            neg_reg  <= numer[31] ^ denom[DIV_DEN_W-1];
            zero_reg <= (denom == '0);
        end else if (busy_reg) begin
            dvd_reg <= q_final;
            rem_reg <= rem_sub;
            if (cnt_reg == CNT_W'(1)) begin
                if (zero_reg) begin
                    quot_reg <= '0;
                end else if (!neg_reg) begin
                    quot_reg <= (q_final > DIV_DVD_W'(32'h7FFF_FFFF))
                              ? 32'sh7FFF_FFFF : 32'(q_final);
                end else begin
                    quot_reg <= (q_final > DIV_DVD_W'(32'h8000_0000))
                              ? 32'sh8000_0000 : 32'(-q_final);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/core/kalman_angle_bias_filter_core.sv -----
// Two-state angle/bias Kalman filter. Each transfer on the input stream carries an
// accelerometer angle and a gyro rate (Q8.24); one transfer with the updated angle
// comes out per sample. The block holds one sample at a time: a sequencer drives a
// shared two-stage multiplier for ten products and a one-bit-per-cycle divider for
// the two gains. The finished result sits in an output register, and the next sample
// is accepted while it waits. Registers are to be written over the APB port only while
// idle; the block itself does not enforce this.
module kalman_angle_bias_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // measured_angle [31:0], measured_rate [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // angle_estimate [31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kabf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_ISSUE    = 5'b00010,
        S_WAIT_MUL = 5'b00100,
        S_WAIT_DIV = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    state_t state_reg;
    step_t  step_reg;

    logic [30:0] angle_noise_reg;
    logic [30:0] bias_noise_reg;
    logic [30:0] measure_noise_reg;
    logic [23:0] sample_period_reg;

    logic signed [31:0] angle_reg, bias_reg, rate_reg, meas_reg;
    logic signed [31:0] cov0_reg, cov1_reg, cov2_reg, cov3_reg;
    logic signed [31:0] w00_reg, w01_reg, w10_reg, w11_reg;
    logic signed [MUL_A_W-1:0]   inner_reg;
    logic signed [DIV_DEN_W-1:0] s_reg;
    logic signed [31:0] k0_reg, k1_reg, y_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic                        mul_start, mul_done;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_RES_W-1:0] mul_res;
    logic signed [WIDE_W-1:0]    r;
    logic                        div_start, div_done;
    logic signed [31:0]          div_num;
    logic signed [31:0]          div_q;
    logic                        is_div;
    logic signed [WIDE_W-1:0]    inner_full;
    logic signed [WIDE_W-1:0]    s_full;
    logic                        in_xfer, cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign in_xfer = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb begin
        unique case (paddr[3:2])
            REG_ANGLE_NOISE:   prdata = {1'b0, angle_noise_reg};
            REG_BIAS_NOISE:    prdata = {1'b0, bias_noise_reg};
            REG_MEASURE_NOISE: prdata = {1'b0, measure_noise_reg};
            REG_SAMPLE_PERIOD: prdata = {8'd0, sample_period_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_noise_reg   <= ANGLE_NOISE_RST;
            bias_noise_reg    <= BIAS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ANGLE_NOISE:   angle_noise_reg   <= pwdata[30:0];
                REG_BIAS_NOISE:    bias_noise_reg    <= pwdata[30:0];
                REG_MEASURE_NOISE: measure_noise_reg <= pwdata[30:0];
                REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    assign is_div = (step_reg == OP_GAIN0) || (step_reg == OP_GAIN1);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = {9'd0, sample_period_reg};
        case (step_reg)
            OP_ANGLE_PRED: mul_a = MUL_A_W'(rate_reg);
            OP_DT_P11:     mul_a = MUL_A_W'(cov3_reg);
            OP_P00_PRED:   mul_a = inner_reg;
            OP_P11_PRED:   mul_a = {3'd0, bias_noise_reg};
            OP_ANGLE_UPD: begin
                mul_a = MUL_A_W'(k0_reg);
                mul_b = MUL_B_W'(y_reg);
            end
            OP_BIAS_UPD: begin
                mul_a = MUL_A_W'(k1_reg);
                mul_b = MUL_B_W'(y_reg);
            end
            OP_P00_UPD: begin
                mul_a = MUL_A_W'(k0_reg);
                mul_b = MUL_B_W'(w00_reg);
            end
            OP_P01_UPD: begin
                mul_a = MUL_A_W'(k0_reg);
                mul_b = MUL_B_W'(w01_reg);
            end
            OP_P10_UPD: begin
                mul_a = MUL_A_W'(k1_reg);
                mul_b = MUL_B_W'(w00_reg);
            end
            OP_P11_UPD: begin
                mul_a = MUL_A_W'(k1_reg);
                mul_b = MUL_B_W'(w01_reg);
            end
            default: ;
        endcase
    end

    assign mul_start = (state_reg == S_ISSUE) && !is_div;
    assign div_start = (state_reg == S_ISSUE) && is_div;
    assign div_num   = (step_reg == OP_GAIN0) ? w00_reg : w10_reg;
    assign r         = WIDE_W'(mul_res);

    assign inner_full = r - sx32(cov1_reg) - sx32(cov2_reg)
                      + WIDE_W'(angle_noise_reg);
    assign s_full     = sx32(w00_reg) + WIDE_W'(measure_noise_reg);

    kabf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    kabf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (s_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= OP_ANGLE_PRED;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= '0;
            rate_reg      <= '0;
            cov0_reg      <= '0;
            cov1_reg      <= '0;
            cov2_reg      <= '0;
            cov3_reg      <= '0;
        end else begin
            if (out_valid_reg && m_axis_tready && (state_reg != S_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        meas_reg  <= s_axis_tdata[31:0];
                        rate_reg  <= sat32(sx32(s_axis_tdata[63:32]) - sx32(bias_reg));
                        step_reg  <= OP_ANGLE_PRED;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    state_reg <= is_div ? S_WAIT_DIV : S_WAIT_MUL;
                end
                S_WAIT_DIV: begin
                    if (div_done) begin
                        if (step_reg == OP_GAIN0) begin
                            k0_reg <= div_q;
                        end else begin
                            k1_reg <= div_q;
                            y_reg  <= sat32(sx32(meas_reg) - sx32(angle_reg));
                        end
                        step_reg  <= step_t'(step_reg + 4'd1);
                        state_reg <= S_ISSUE;
                    end
                end
                S_WAIT_MUL: begin
                    if (mul_done) begin
                        step_reg  <= (step_reg == OP_P11_UPD) ? OP_ANGLE_PRED
                                                              : step_t'(step_reg + 4'd1);
                        state_reg <= (step_reg == OP_P11_UPD) ? S_DONE : S_ISSUE;
                        case (step_reg)
                            OP_ANGLE_PRED: angle_reg <= sat32(sx32(angle_reg) + r);
                            OP_DT_P11: begin
                                inner_reg <= inner_full[MUL_A_W-1:0];
                                w01_reg   <= sat32(sx32(cov1_reg) - r);
                                w10_reg   <= sat32(sx32(cov2_reg) - r);
                            end
                            OP_P00_PRED: w00_reg <= sat32(sx32(cov0_reg) + r);
                            OP_P11_PRED: begin
                                w11_reg <= sat32(sx32(cov3_reg) + r);
                                s_reg   <= s_full[DIV_DEN_W-1:0];
                            end
                            OP_ANGLE_UPD: angle_reg <= sat32(sx32(angle_reg) + r);
                            OP_BIAS_UPD:  bias_reg  <= sat32(sx32(bias_reg) + r);
                            OP_P00_UPD:   cov0_reg  <= sat32(sx32(w00_reg) - r);
                            OP_P01_UPD:   cov1_reg  <= sat32(sx32(w01_reg) - r);
                            OP_P10_UPD:   cov2_reg  <= sat32(sx32(w10_reg) - r);
                            OP_P11_UPD:   cov3_reg  <= sat32(sx32(w11_reg) - r);
                            default: ;
                        endcase
                    end
                end
                S_DONE: begin
                    if (!out_valid_reg || m_axis_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= angle_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kabf_pkg::*;

    class angle_filter_scoreboard;
        longint noise_angle, noise_bias, noise_meas, period;
        longint angle_est, bias_est, rate_est;
        longint cov[4];
        logic [31:0] angle_q[$];
        int errors;

        function new();
            noise_angle = ANGLE_NOISE_RST;
            noise_bias  = BIAS_NOISE_RST;
            noise_meas  = MEASURE_NOISE_RST;
            period      = SAMPLE_PERIOD_RST;
            angle_est = 0;
            bias_est  = 0;
            rate_est  = 0;
            foreach (cov[i]) cov[i] = 0;
            errors = 0;
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // fixed-point product, rounded half up
        function longint fmul(longint a, longint b);
            return (a * b + (64'sd1 <<< 23)) >>> FRAC_BITS;
        endfunction

        function longint kgain(longint num, longint den);
            if (den == 0) return 0;
            return clip((num <<< FRAC_BITS) / den);
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_ANGLE_NOISE:   noise_angle = longint'(val[30:0]);
                REG_BIAS_NOISE:    noise_bias  = longint'(val[30:0]);
                REG_MEASURE_NOISE: noise_meas  = longint'(val[30:0]);
                REG_SAMPLE_PERIOD: period      = longint'(val[23:0]);
                default: ;
            endcase
        endfunction

        function void note_sample(logic [31:0] meas_angle, logic [31:0] meas_rate);
            longint ma, mr, p00, p01, p10, p11, inner, s, k0, k1, y;
            ma = longint'(signed'(meas_angle));
            mr = longint'(signed'(meas_rate));
            p00 = cov[0];
            p01 = cov[1];
            p10 = cov[2];
            p11 = cov[3];
            rate_est  = clip(mr - bias_est);
            angle_est = clip(angle_est + fmul(period, rate_est));
            inner = fmul(period, p11) - p01 - p10 + noise_angle;
            p00 = clip(p00 + fmul(period, inner));
            p01 = clip(p01 - fmul(period, p11));
            p10 = clip(p10 - fmul(period, p11));
            p11 = clip(p11 + fmul(noise_bias, period));
            s  = p00 + noise_meas;
            k0 = kgain(p00, s);
            k1 = kgain(p10, s);
            y  = clip(ma - angle_est);
            angle_est = clip(angle_est + fmul(k0, y));
            bias_est  = clip(bias_est + fmul(k1, y));
            cov[0] = clip(p00 - fmul(k0, p00));
            cov[1] = clip(p01 - fmul(k0, p01));
            cov[2] = clip(p10 - fmul(k1, p00));
            cov[3] = clip(p11 - fmul(k1, p01));
            angle_q.push_back(angle_est[31:0]);
        endfunction

        function void check_angle(logic [31:0] got);
            logic [31:0] want;
            if (angle_q.size() == 0) begin
                $display("%0t: unexpected angle transfer, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = angle_q.pop_front();
            if (got !== want) begin
                $display("%0t: angle_estimate mismatch, expected %h, got %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    angle_filter_scoreboard sb = new();
    bit steady = 1'b0;      // no idling on either side
    int hold_cycles = 0;    // long receiver hold-off request

    always #10 aclk = ~aclk;

    kalman_angle_bias_filter_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        #30ms;
        $display("tb_top: errors");
        $finish;
    end

    // result side
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
            end
            n = steady ? 0 : $urandom_range(0, 14);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_axis_tvalid));
            sb.check_angle(m_axis_tdata);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(logic [31:0] ang, logic [31:0] rate);
        int n;
        n = steady ? 0 : $urandom_range(0, 14);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_axis_tdata  <= {rate, ang};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_sample(ang, rate);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.angle_q.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(logic [30:0] an, logic [30:0] bn, logic [30:0] mn,
                             logic [23:0] dt);
        wait_idle();
        write_reg(REG_ANGLE_NOISE, {1'b0, an});
        write_reg(REG_BIAS_NOISE, {1'b0, bn});
        write_reg(REG_MEASURE_NOISE, {1'b0, mn});
        write_reg(REG_SAMPLE_PERIOD, {8'd0, dt});
    endtask

    function automatic logic [31:0] pick_value(int kind);
        logic [31:0] corner[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
        case (kind)
            0, 1, 2, 3, 4: return 32'($signed($urandom_range(0, 11796480)) - 5898240);
            5, 6, 7:       return $urandom();
            default:       return corner[$urandom_range(0, 4)];
        endcase
    endfunction

    task automatic random_run(int count);
        repeat (count) send_sample(pick_value($urandom_range(0, 8)),
                                   pick_value($urandom_range(0, 8)));
    endtask

    initial begin
        logic [31:0] edge_vals[5] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'hFFFF_FFFF, 32'h0001_0000};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corners of angle and rate under reset settings
        foreach (edge_vals[i])
            foreach (edge_vals[j])
                if (i < 4) send_sample(edge_vals[i], edge_vals[j]);

        random_run(200);

        // long hold-off with the input kept busy so the block stalls
        write_all(31'd16777, 31'd50332, 31'd503316, 24'd167772);
        steady = 1'b1;
        hold_cycles = 2000;
        random_run(150);
        steady = 1'b0;

        write_all(31'd0, 31'd0, 31'd1, 24'd1);
        random_run(150);
        write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF);
        random_run(150);
        write_all(31'd0, 31'h7FFF_FFFF, 31'd1, 24'hFF_FFFF);
        random_run(150);
        write_all(31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 24'd1);
        random_run(150);
        repeat (4) begin
            write_all(31'($urandom()), 31'($urandom()), 31'($urandom_range(1, 32'h7FFF_FFFF)),
                      24'($urandom_range(1, 24'hFF_FFFF)));
            steady = ($urandom_range(0, 2) == 0);
            random_run(150);
            steady = 1'b0;
        end
        write_all(31'($urandom_range(0, 200000)), 31'($urandom_range(0, 200000)),
                  31'($urandom_range(1, 2000000)), 24'($urandom_range(1, 400000)));
        random_run(130);

        wait_idle();
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
